// File: hdl/esenv_pkg.sv
// Package for the eased segment envelope: sizes, codes, state types and the
// query record that travels down the row of segment cells. No dependencies.
`default_nettype none
package esenv_pkg;
	localparam int MAX_SEGMENTS = 16;
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_CLEAR  = 2'd1;
	localparam logic [1:0] KIND_EVAL   = 2'd2;
	localparam logic [1:0] KIND_RSVD   = 2'd3;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	localparam logic [2:0] EASE_LINEAR = 3'd0;
	localparam logic [2:0] EASE_HOLD   = 3'd1;
	localparam logic [2:0] EASE_SQUARE = 3'd2;
	localparam logic [2:0] EASE_MIRROR = 3'd3;
	localparam logic [2:0] EASE_DECEL  = 3'd4;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	typedef enum logic [1:0] {T_IDLE, T_SEARCH, T_MATH} top_state_t;
	typedef enum logic [2:0] {M_IDLE, M_DIV, M_SQ, M_EO, M_EO2, M_MUL, M_ADD, M_SCL}
		math_state_t;

	typedef struct packed {
		logic        vld;
		logic        started;
		logic        found;
		logic [31:0] off;
		logic [31:0] cur_t;
		logic [31:0] cur_v;
		logic [2:0]  cur_e;
		logic        has_nxt;
		logic [31:0] nxt_t;
		logic [31:0] nxt_v;
	} query_t;
endpackage
`default_nettype wire

// File: hdl/esenv_cell.sv
// One segment cell: holds a segment and advances the search query by one cell.
// Depends on esenv_pkg.
`default_nettype none
module esenv_cell
	import esenv_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [31:0] wr_time,
	input  wire logic [31:0] wr_value,
	input  wire logic [2:0]  wr_ease,
	input  wire logic        occupied,
	input  wire query_t      q_in,
	output query_t           q_out
);
	logic [31:0] t_q;
	logic [31:0] v_q;
	logic [2:0]  e_q;
	query_t      q_next;
	logic        vld_s1;
	query_t      q_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			t_q <= wr_time;
			v_q <= wr_value;
			e_q <= wr_ease;
		end
	end

	always_comb begin
		q_next = q_in;
		if (q_in.vld && occupied) begin
			if (!q_in.started) begin
				q_next.started = 1'b1;
				q_next.cur_t = t_q;
				q_next.cur_v = v_q;
				q_next.cur_e = e_q;
			end else if (!q_in.found) begin
				if (q_in.off > t_q) begin
					q_next.cur_t = t_q;
					q_next.cur_v = v_q;
					q_next.cur_e = e_q;
				end else begin
					q_next.found = 1'b1;
					q_next.has_nxt = 1'b1;
					q_next.nxt_t = t_q;
					q_next.nxt_v = v_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= q_next.vld;
		end
	end

	always_ff @(posedge clk) begin
		q_s1 <= q_next;
	end

	always_comb begin
		q_out = q_s1;
		q_out.vld = vld_s1;
	end
endmodule
`default_nettype wire

// File: hdl/esenv_math.sv
// Sequenced arithmetic: progress division, easing, interpolation, scaling.
// Depends on esenv_pkg.
`default_nettype none
module esenv_math
	import esenv_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire query_t      q,
	input  wire logic [31:0] base,
	output logic             done,
	output logic [31:0]      result
);
	math_state_t state_q, state_d;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] len_q;
	logic [16:0] p_q;
	logic [33:0] sq_q;
	logic [2:0]  ease_q;
	logic [31:0] v0_q;
	logic [31:0] v1_q;
	logic [31:0] base_q;
	logic signed [50:0] mul_q;
	logic signed [34:0] v_q;
	logic signed [66:0] scl_q;

	logic [32:0] trial;
	logic        fits;
	logic [31:0] elapsed;
	logic        zero_p;
	logic [16:0] bval;
	logic [16:0] sq_hi;
	logic signed [32:0] diff;
	logic signed [50:0] r;

	assign trial = (cnt_q == 5'd0) ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign fits = trial >= {1'b0, len_q};
	assign zero_p = !(q.cur_t < q.nxt_t && q.off > q.cur_t);
	assign bval = ONE_Q16 - p_q;
	assign sq_hi = sq_q[32:16];
	assign diff = $signed({v1_q[31], v1_q}) - $signed({v0_q[31], v0_q});
	assign r = 51'(scl_q >>> 16);

	always_comb begin
		elapsed = q.off - q.cur_t;
		if (elapsed > q.nxt_t - q.cur_t)
			elapsed = q.nxt_t - q.cur_t;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			M_IDLE: begin
				if (go) begin
					if (!q.has_nxt)
						state_d = M_ADD;
					else if (zero_p)
						state_d = M_SQ;
					else
						state_d = M_DIV;
				end
			end
			M_DIV: if (cnt_q == 5'd16) state_d = M_SQ;
			M_SQ: state_d = M_EO;
			M_EO: state_d = (ease_q == EASE_DECEL) ? M_EO2 : M_MUL;
			M_EO2: state_d = M_MUL;
			M_MUL: state_d = M_ADD;
			M_ADD: state_d = M_SCL;
			M_SCL: state_d = M_IDLE;
			default: state_d = M_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= (state_q == M_SCL);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				cnt_q <= 5'd0;
				rem_q <= elapsed;
				len_q <= q.nxt_t - q.cur_t;
				p_q <= 17'd0;
				ease_q <= q.cur_e;
				v0_q <= q.cur_v;
				v1_q <= q.nxt_v;
				base_q <= base;
				v_q <= 35'(signed'(q.cur_v));
				mul_q <= '0;
			end
			M_DIV: begin
				cnt_q <= cnt_q + 5'd1;
				rem_q <= fits ? 32'(trial - {1'b0, len_q}) : trial[31:0];
				p_q <= {p_q[15:0], fits};
			end
			M_SQ: begin
				if (ease_q == EASE_DECEL)
					sq_q <= {17'd0, bval} * {17'd0, bval};
				else
					sq_q <= {17'd0, p_q} * {17'd0, p_q};
			end
			M_EO: begin
				case (ease_q)
					EASE_HOLD: p_q <= 17'd0;
					EASE_SQUARE: p_q <= sq_hi;
					EASE_MIRROR: p_q <= bval;
					EASE_DECEL: sq_q <= {17'd0, p_q} * {17'd0, ONE_Q16 - sq_hi};
					default: p_q <= p_q;
				endcase
			end
			M_EO2: p_q <= sq_hi;
			M_MUL: mul_q <= diff * $signed({1'b0, p_q});
			M_ADD: begin
				if (mul_q != '0 || v_q != 35'(signed'(v0_q)))
					v_q <= 35'(signed'(v0_q)) + 35'(mul_q >>> 16);
				scl_q <= '0;
			end
			M_SCL: scl_q <= $signed(base_q) * v_q;
			default: cnt_q <= cnt_q;
		endcase
	end

	// result sampled by the top when done is high
	always_comb begin
		if (r > 51'sd2147483647)
			result = 32'h7FFFFFFF;
		else if (r < -51'sd2147483648)
			result = 32'h80000000;
		else
			result = r[31:0];
	end
endmodule
`default_nettype wire

// File: hdl/eased_segment_envelope_core.sv
// Append, clear, unknown and empty-table evaluate: done strobes in the cycle after the
// accepting edge and busy stays low, so these transactions can follow back to back.
// Evaluate: the query passes the row of MAX_SEGMENTS registered cells, then the math
// sequence, which skips the division with no successor or with zero progress and otherwise
// runs the 17-step progress division; busy falls with done.
// The receiver cannot stall results. arst_n empties the table and idles all control.
`default_nettype none
module eased_segment_envelope_core
	import esenv_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] seg_time,
	input  wire logic [31:0] seg_value,
	input  wire logic [2:0]  seg_ease,
	input  wire logic [31:0] offset,
	input  wire logic [31:0] gain,
	output logic             done,
	output logic [31:0]      value,
	output logic [1:0]       status
);
	top_state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [31:0]      base_q;
	logic             accept;
	logic             launch;
	logic             math_go;
	logic             math_done;
	logic [31:0]      math_result;
	query_t           seed;
	query_t           chain [MAX_SEGMENTS+1];
	logic             done_q;
	logic [31:0]      value_q;
	logic [1:0]       status_q;

	assign accept = start && !busy;
	assign busy = (state_q != T_IDLE);

	// Seed the query: no segment picked yet, cell 0 takes the first segment.
	always_comb begin
		seed = '0;
		seed.vld = launch;
		seed.off = offset;
	end

	assign chain[0] = seed;

	for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
		esenv_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (accept && kind == KIND_APPEND && count_q == CNT_W'(i)),
			.wr_time  (seg_time),
			.wr_value (seg_value),
			.wr_ease  (seg_ease),
			.occupied (count_q > CNT_W'(i)),
			.q_in     (chain[i]),
			.q_out    (chain[i+1])
		);
	end

	esenv_math u_math (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (math_go),
		.q      (chain[MAX_SEGMENTS]),
		.base   (base_q),
		.done   (math_done),
		.result (math_result)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			T_IDLE: if (launch) state_d = T_SEARCH;
			T_SEARCH: if (chain[MAX_SEGMENTS].vld) state_d = T_MATH;
			T_MATH: if (math_done) state_d = T_IDLE;
			default: state_d = T_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		launch = 1'b0;
		math_go = 1'b0;
		unique case (state_q)
			T_IDLE: launch = accept && kind == KIND_EVAL && count_q != '0;
			T_SEARCH: math_go = chain[MAX_SEGMENTS].vld;
			T_MATH: math_go = 1'b0;
			default: launch = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			count_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (accept && !launch) || (state_q == T_MATH && math_done);
			if (accept) begin
				if (kind == KIND_APPEND && count_q != CNT_W'(MAX_SEGMENTS))
					count_q <= count_q + CNT_W'(1);
				else if (kind == KIND_CLEAR)
					count_q <= '0;
			end
		end
	end

	// hold the scale; drive the result transaction
	always_ff @(posedge clk) begin
		if (launch)
			base_q <= gain;
		if (state_q == T_MATH && math_done) begin
			value_q <= math_result;
			status_q <= STATUS_OK;
		end else if (accept) begin
			value_q <= '0;
			if (kind == KIND_APPEND && count_q == CNT_W'(MAX_SEGMENTS))
				status_q <= STATUS_FULL;
			else if (kind == KIND_EVAL && count_q == '0)
				status_q <= STATUS_EMPTY;
			else
				status_q <= STATUS_OK;
		end
	end

	assign done = done_q;
	assign value = value_q;
	assign status = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SEGMENTS))
		else $error("segment count past table size");
	a_chain_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		chain[MAX_SEGMENTS].vld |-> state_q == T_SEARCH)
		else $error("query left the cell row outside search");
	a_math_in_phase: assert property (@(posedge clk) disable iff (!arst_n)
		math_done |-> state_q == T_MATH)
		else $error("math finished outside math phase");
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_FULL) |-> count_q == CNT_W'(MAX_SEGMENTS))
		else $error("full status with room in table");
endmodule
`default_nettype wire

// File: sim/eased_segment_envelope_core_tb.sv
// Self-checking testbench for eased_segment_envelope_core: drives append, clear,
// evaluate and unknown-kind commands and checks every result against an in-bench
// envelope predictor. Depends on esenv_pkg and the core RTL.
`default_nettype none
module eased_segment_envelope_core_tb;
	import esenv_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  kind = KIND_CLEAR;
	logic [31:0] seg_time = '0;
	logic [31:0] seg_value = '0;
	logic [2:0]  seg_ease = EASE_LINEAR;
	logic [31:0] offset = '0;
	logic [31:0] gain = '0;
	logic        done;
	logic [31:0] value;
	logic [1:0]  status;

	typedef struct {
		logic [31:0] value;
		logic [1:0]  status;
	} env_result_t;

	// Predictor copy of the segment table
	logic [31:0] tbl_time [MAX_SEGMENTS];
	logic [31:0] tbl_value [MAX_SEGMENTS];
	logic [2:0]  tbl_ease [MAX_SEGMENTS];
	int          tbl_count = 0;

	env_result_t pending_results[$];
	int          n_errors = 0;
	int          n_checked = 0;
	int          n_evals = 0;
	int          n_full = 0;
	longint      cycle_count = 0;
	bit          quiet_mode = 0;
	logic [31:0] last_time = '0;

	localparam longint CYCLE_LIMIT = 400000;

	always #5 clk = ~clk;

	eased_segment_envelope_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.seg_time(seg_time), .seg_value(seg_value), .seg_ease(seg_ease),
		.offset(offset), .gain(gain), .done(done), .value(value),
		.status(status)
	);

	// Floor of x / 65536 (arithmetic shift floors toward minus infinity)
	function automatic longint floor_q16(longint x);
		return x >>> 16;
	endfunction

	function automatic logic [31:0] scale_clip(longint base, longint v);
		longint r;
		r = floor_q16(base * v);
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return r[31:0];
	endfunction

	function automatic longint eased_progress(logic [2:0] mode, longint p);
		longint b, c;
		case (mode)
			EASE_HOLD: return 0;
			EASE_SQUARE: return (p * p) >>> 16;
			EASE_MIRROR: return 65536 - p;
			EASE_DECEL: begin
				b = 65536 - p;
				c = (b * b) >>> 16;
				return (p * (65536 - c)) >>> 16;
			end
			default: return p;
		endcase
	endfunction

	// Compute the result of one command and update the table copy
	function automatic env_result_t envelope_predict(logic [1:0] k, logic [31:0] st,
			logic [31:0] sv, logic [2:0] se, logic [31:0] off, logic [31:0] bv);
		env_result_t r;
		int i;
		longint t0, t1, v0, v1, p, el, len, base;
		r.value = '0;
		r.status = STATUS_OK;
		if (k == KIND_APPEND) begin
			if (tbl_count >= MAX_SEGMENTS)
				r.status = STATUS_FULL;
			else begin
				tbl_time[tbl_count] = st;
				tbl_value[tbl_count] = sv;
				tbl_ease[tbl_count] = se;
				tbl_count++;
			end
		end else if (k == KIND_CLEAR) begin
			tbl_count = 0;
		end else if (k == KIND_EVAL) begin
			if (tbl_count == 0)
				r.status = STATUS_EMPTY;
			else begin
				base = longint'(signed'(bv));
				i = 0;
				while (i + 1 < tbl_count && off > tbl_time[i + 1])
					i++;
				if (i + 1 >= tbl_count)
					r.value = scale_clip(base, longint'(signed'(tbl_value[i])));
				else begin
					t0 = tbl_time[i];
					t1 = tbl_time[i + 1];
					v0 = longint'(signed'(tbl_value[i]));
					v1 = longint'(signed'(tbl_value[i + 1]));
					p = 0;
					if (t1 > t0 && longint'(off) > t0) begin
						el = longint'(off) - t0;
						len = t1 - t0;
						if (el > len)
							el = len;
						p = (el << 16) / len;
					end
					p = eased_progress(tbl_ease[i], p);
					r.value = scale_clip(base, v0 + floor_q16((v1 - v0) * p));
				end
			end
		end
		return r;
	endfunction

	// Send one transaction: random pre-gap, then hold start until accepted
	task automatic send_cmd(logic [1:0] k, logic [31:0] st, logic [31:0] sv,
			logic [2:0] se, logic [31:0] off, logic [31:0] bv);
		env_result_t exp_r;
		while (!quiet_mode && $urandom_range(99) < 11) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		seg_time <= st;
		seg_value <= sv;
		seg_ease <= se;
		offset <= off;
		gain <= bv;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		exp_r = envelope_predict(k, st, sv, se, off, bv);
		pending_results.push_back(exp_r);
		if (k == KIND_EVAL)
			n_evals++;
		if (exp_r.status == STATUS_FULL)
			n_full++;
	endtask

	task automatic append_seg(logic [31:0] st, logic [31:0] sv, logic [2:0] se);
		send_cmd(KIND_APPEND, st, sv, se, $urandom, $urandom);
	endtask

	task automatic eval_at(logic [31:0] off, logic [31:0] bv);
		send_cmd(KIND_EVAL, $urandom, $urandom, 3'($urandom), off, bv);
	endtask

	task automatic clear_table();
		send_cmd(KIND_CLEAR, $urandom, $urandom, 3'($urandom), $urandom, $urandom);
		last_time = '0;
	endtask

	// Check each result strobe against the oldest expectation
	always @(posedge clk) begin
		env_result_t exp_r;
		cycle_count <= cycle_count + 1;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: value %h status %0d", value, status);
				n_errors++;
			end else begin
				exp_r = pending_results.pop_front();
				n_checked++;
				if (value !== exp_r.value) begin
					$error("value: expected %h actual %h", exp_r.value, value);
					n_errors++;
				end
				if (status !== exp_r.status) begin
					$error("status: expected %0d actual %0d", exp_r.status, status);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Empty-table evaluate, then unknown kind, then extremes of every field
	task automatic test_directed();
		eval_at(32'h0, 32'h0001_0000);
		send_cmd(KIND_RSVD, 32'hFFFF_FFFF, 32'h8000_0000, 3'd7, 32'hFFFF_FFFF,
			32'h7FFF_FFFF);
		append_seg(32'd100, 32'h0001_0000, EASE_LINEAR);
		append_seg(32'd200, 32'h0003_0000, EASE_HOLD);
		append_seg(32'd300, 32'hFFFE_0000, EASE_SQUARE);
		append_seg(32'd300, 32'h7FFF_FFFF, EASE_MIRROR);
		append_seg(32'd500, 32'h8000_0000, EASE_DECEL);
		append_seg(32'd400, 32'h0000_0000, 3'd6);
		append_seg(32'hFFFF_FFFF, 32'h1234_5678, 3'd7);
		eval_at(32'd0, 32'h0001_0000);
		eval_at(32'd150, 32'h0001_0000);
		eval_at(32'd250, 32'hFFFF_0000);
		eval_at(32'd300, 32'h7FFF_FFFF);
		eval_at(32'd350, 32'h8000_0000);
		eval_at(32'd450, 32'h0002_8000);
		eval_at(32'h8000_0000, 32'h7FFF_FFFF);
		eval_at(32'hFFFF_FFFF, 32'h8000_0000);
		clear_table();
		eval_at(32'd5, 32'h0001_0000);
	endtask

	// Fill past capacity to hit the full-table status
	task automatic test_full_table();
		for (int i = 0; i < MAX_SEGMENTS + 2; i++)
			append_seg(32'(i * 10), $urandom, 3'($urandom_range(7)));
		eval_at(32'd75, $urandom);
		eval_at(32'hFFFF_FFFF, $urandom);
	endtask

	// Mostly well-formed tables with sorted times, evaluated at many offsets
	task automatic test_random(int n_items);
		int sent;
		int step;
		sent = 0;
		while (sent < n_items) begin
			clear_table();
			sent++;
			step = $urandom_range(3) == 0 ? 32'h1000_0000 : $urandom_range(1000);
			for (int s = $urandom_range(1, MAX_SEGMENTS + 1); s > 0; s--) begin
				if ($urandom_range(9) == 0)
					append_seg($urandom, $urandom, 3'($urandom));
				else begin
					last_time = last_time + 32'($urandom_range(step));
					append_seg(last_time, $urandom_range(1) ? $urandom :
						32'($signed($urandom_range(0, 32'h40000)) - 32'sh20000),
						3'($urandom_range(4)));
				end
				sent++;
			end
			for (int e = $urandom_range(2, 10); e > 0; e--) begin
				eval_at($urandom_range(3) == 0 ? $urandom :
					32'($urandom_range(last_time + 32'd50)),
					$urandom_range(1) ? $urandom :
					32'($signed($urandom_range(0, 32'h40000)) - 32'sh20000));
				sent++;
			end
			if ($urandom_range(15) == 0) begin
				send_cmd(KIND_RSVD, $urandom, $urandom, 3'($urandom), $urandom,
					$urandom);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_random(400);
		quiet_mode = 1;
		test_random(150);
		quiet_mode = 0;
		test_random(350);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		$display("checked %0d results: %0d evaluates, %0d full-table appends",
			n_checked, n_evals, n_full);
		if (n_errors == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
